// ===== rtl/bhsc_pkg.sv =====
package bhsc_pkg;

	localparam int DUTY_W     = 16;
	localparam int SPEED_W    = 16;
	localparam int RAMP_W     = 17;
	localparam int FUNC_W     = 4;
	localparam int MODE_W     = 2;
	localparam int CODE_W     = 3;
	localparam int POS_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int N_PHASE    = 3;

	// register defaults
	localparam logic [DUTY_W-1:0]  PWM_PERIOD_RST  = 16'd10000;
	localparam logic [SPEED_W-1:0] SPEED_CAP_RST   = 16'd8800;
	localparam logic [SPEED_W-1:0] JUMP_LIMIT_RST  = 16'd1320;
	localparam logic [SPEED_W-1:0] RAMP_DELAY_RST  = 16'd100;
	localparam logic [POS_W-1:0]   HALL_A_BASE_RST = 2'd0;
	localparam logic [POS_W-1:0]   HALL_B_BASE_RST = 2'd1;
	localparam logic [POS_W-1:0]   HALL_C_BASE_RST = 2'd2;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK       = 4'd0,
		FN_SET_SPEED  = 4'd1,
		FN_SET_MODE   = 4'd2,
		FN_FORWARD    = 4'd3,
		FN_BACKWARD   = 4'd4,
		FN_SET_DIR    = 4'd5,
		FN_TOGGLE_DIR = 4'd6,
		FN_NEXT_ORDER = 4'd7,
		FN_START      = 4'd8
	} func_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_SOFT = 2'd0,
		MODE_HARD = 2'd1,
		MODE_RUN  = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PWM_PERIOD  = 3'd0,
		CFG_SPEED_CAP   = 3'd1,
		CFG_JUMP_LIMIT  = 3'd2,
		CFG_RAMP_DELAY  = 3'd3,
		CFG_HALL_A_BASE = 3'd4,
		CFG_HALL_B_BASE = 3'd5,
		CFG_HALL_C_BASE = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ROLE_OFF  = 2'd0,
		ROLE_HIGH = 2'd1,
		ROLE_LOW  = 2'd2
	} role_t;

	typedef struct packed {
		role_t a;
		role_t b;
		role_t c;
	} roles_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic               hall_a;
		logic               hall_b;
		logic               hall_c;
		logic [SPEED_W-1:0] speed_value;
		logic [MODE_W-1:0]  mode_value;
		logic               dir_value;
	} cmd_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  pwm_period;
		logic [SPEED_W-1:0] speed_cap;
		logic [SPEED_W-1:0] jump_limit;
		logic [SPEED_W-1:0] ramp_delay;
	} drive_cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] a_base;
		logic [POS_W-1:0] b_base;
		logic [POS_W-1:0] c_base;
	} order_cfg_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty_a;
		logic [DUTY_W-1:0]  duty_b;
		logic [DUTY_W-1:0]  duty_c;
		logic               pin_a;
		logic               pin_b;
		logic               pin_c;
		logic [MODE_W-1:0]  run_mode;
		logic [SPEED_W-1:0] now_speed;
		logic [SPEED_W-1:0] goal_speed;
		logic [CODE_W-1:0]  hall_code;
	} res_t;

	// six-step table: phase roles per hall code
	function automatic roles_t step_roles(input logic [CODE_W-1:0] code);
		roles_t r;
		case (code)
			3'd1: r = '{ROLE_HIGH, ROLE_LOW,  ROLE_OFF};
			3'd2: r = '{ROLE_OFF,  ROLE_HIGH, ROLE_LOW};
			3'd3: r = '{ROLE_HIGH, ROLE_OFF,  ROLE_LOW};
			3'd4: r = '{ROLE_LOW,  ROLE_OFF,  ROLE_HIGH};
			3'd5: r = '{ROLE_OFF,  ROLE_LOW,  ROLE_HIGH};
			3'd6: r = '{ROLE_LOW,  ROLE_HIGH, ROLE_OFF};
			default: r = '{ROLE_OFF, ROLE_OFF, ROLE_OFF};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/bhsc_hall_order.sv =====
module bhsc_hall_order (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  bhsc_pkg::cmd_t                  cmd,
	input  bhsc_pkg::order_cfg_t            ocfg,
	output logic [bhsc_pkg::CODE_W-1:0]     code
);
	import bhsc_pkg::*;

	logic             row_sel_q;
	logic [POS_W-1:0] rot_q [2];
	logic [POS_W-1:0] bp_q  [N_PHASE];

	logic             row_n;
	logic [POS_W-1:0] rot_old, rot_n;
	logic [POS_W-1:0] a_fix, b_fix, c_fix, b_sel, c_sel;
	logic [POS_W-1:0] bp_n [N_PHASE];
	logic             step;

	// base register value three counts as zero
	function automatic logic [POS_W-1:0] base_fix(input logic [POS_W-1:0] b);
		return (b == 2'd3) ? 2'd0 : b;
	endfunction

	// (x + r) mod 3 with both below three
	function automatic logic [POS_W-1:0] add_mod3(input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] r);
		logic [POS_W:0] s;
		s = {1'b0, x} + {1'b0, r};
		if (s >= 3'd3) begin
			s = s - 3'd3;
		end
		return s[POS_W-1:0];
	endfunction

	assign step  = fire && (func_t'(cmd.func) == FN_NEXT_ORDER);
	assign row_n = ~row_sel_q;

	always_comb begin
		rot_old = rot_q[row_n];
		rot_n   = (rot_old >= 2'd2) ? 2'd0 : rot_old + 2'd1;
		a_fix   = base_fix(ocfg.a_base);
		b_fix   = base_fix(ocfg.b_base);
		c_fix   = base_fix(ocfg.c_base);
		b_sel   = row_n ? c_fix : b_fix;
		c_sel   = row_n ? b_fix : c_fix;
		bp_n[0] = add_mod3(a_fix, rot_n);
		bp_n[1] = add_mod3(b_sel, rot_n);
		bp_n[2] = add_mod3(c_sel, rot_n);
	end

	always_comb begin
		for (int k = 0; k < CODE_W; k++) begin
			code[k] = (cmd.hall_a && (bp_q[0] == POS_W'(k)))
			        | (cmd.hall_b && (bp_q[1] == POS_W'(k)))
			        | (cmd.hall_c && (bp_q[2] == POS_W'(k)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sel_q <= 1'b0;
			rot_q[0]  <= '0;
			rot_q[1]  <= '0;
			for (int i = 0; i < N_PHASE; i++) begin
				bp_q[i] <= '0;
			end
		end else if (step) begin
			row_sel_q    <= row_n;
			rot_q[row_n] <= rot_n;
			for (int i = 0; i < N_PHASE; i++) begin
				bp_q[i] <= bp_n[i];
			end
		end
	end

	a_bp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bp_q[0] != 2'd3) && (bp_q[1] != 2'd3) && (bp_q[2] != 2'd3))
		else $error("hall bit position out of range");

endmodule

// ===== rtl/bhsc_motor_ctl.sv =====
module bhsc_motor_ctl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  bhsc_pkg::cmd_t                  cmd,
	input  bhsc_pkg::drive_cfg_t            dcfg,
	input  logic [bhsc_pkg::CODE_W-1:0]     code,
	output bhsc_pkg::res_t                  res
);
	import bhsc_pkg::*;

	logic [DUTY_W-1:0]  duty_q [N_PHASE];
	logic               pin_q  [N_PHASE];
	logic [MODE_W-1:0]  mode_q;
	logic [SPEED_W-1:0] cur_q, tgt_q;
	logic [RAMP_W-1:0]  ramp_q;
	logic               dir_q;
	logic [CODE_W-1:0]  code_q;

	logic [DUTY_W-1:0]  duty_n [N_PHASE];
	logic               pin_n  [N_PHASE];
	logic [MODE_W-1:0]  mode_n;
	logic [SPEED_W-1:0] cur_s, cur_n, tgt_n;
	logic [RAMP_W-1:0]  ramp_n;
	logic               dir_n;
	logic [CODE_W-1:0]  code_n;

	logic [SPEED_W-1:0] v_clamp;
	logic               v_change, v_jump, speed_cmd;
	logic               tick, zero;
	roles_t             roles;
	role_t              role [N_PHASE];
	func_t              fn;

	assign fn       = func_t'(cmd.func);
	assign v_clamp  = (cmd.speed_value > dcfg.speed_cap) ? dcfg.speed_cap : cmd.speed_value;
	assign v_change = (cmd.speed_value != tgt_q);
	assign v_jump   = (v_clamp > cur_q) && ((v_clamp - cur_q) > dcfg.jump_limit);
	assign roles    = step_roles(code);
	assign role[0]  = roles.a;
	assign role[1]  = roles.b;
	assign role[2]  = roles.c;

	// command decode: mode, direction, speeds, and whether a tick follows
	always_comb begin
		dir_n     = dir_q;
		mode_n    = mode_q;
		cur_s     = cur_q;
		tgt_n     = tgt_q;
		tick      = 1'b0;
		zero      = 1'b0;
		speed_cmd = 1'b0;
		case (fn)
			FN_TICK:       tick = 1'b1;
			FN_SET_SPEED:  speed_cmd = 1'b1;
			FN_FORWARD: begin
				dir_n     = 1'b1;
				speed_cmd = 1'b1;
			end
			FN_BACKWARD: begin
				dir_n     = 1'b0;
				speed_cmd = 1'b1;
			end
			FN_SET_MODE: begin
				if ((cmd.mode_value <= MODE_RUN) && (cmd.mode_value != mode_q)) begin
					mode_n = cmd.mode_value;
					tick   = 1'b1;
				end
			end
			FN_SET_DIR:    dir_n = cmd.dir_value;
			FN_TOGGLE_DIR: dir_n = ~dir_q;
			FN_START: begin
				mode_n = MODE_RUN;
				tick   = 1'b1;
			end
			default: ;
		endcase
		if (speed_cmd && v_change) begin
			tgt_n = v_clamp;
			if (!v_jump) begin
				cur_s = v_clamp;
			end
			if (v_clamp == '0) begin
				if (mode_q != MODE_SOFT) begin
					mode_n = MODE_SOFT;
					zero   = 1'b1;
				end
			end else begin
				mode_n = MODE_RUN;
				tick   = 1'b1;
			end
		end
	end

	// tick or zero-speed stop: ramp and phase outputs
	always_comb begin
		cur_n  = cur_s;
		ramp_n = ramp_q;
		code_n = code_q;
		for (int i = 0; i < N_PHASE; i++) begin
			duty_n[i] = duty_q[i];
			pin_n[i]  = pin_q[i];
		end
		if (zero) begin
			for (int i = 0; i < N_PHASE; i++) begin
				duty_n[i] = '0;
			end
		end
		if (tick) begin
			case (mode_n)
				MODE_SOFT: begin
					for (int i = 0; i < N_PHASE; i++) begin
						duty_n[i] = '0;
					end
				end
				MODE_HARD: begin
					for (int i = 0; i < N_PHASE; i++) begin
						duty_n[i] = cur_s;
						pin_n[i]  = 1'b0;
					end
				end
				MODE_RUN: begin
					if (cur_s < tgt_n) begin
						if (ramp_q > {1'b0, dcfg.ramp_delay}) begin
							cur_n  = cur_s + 1'b1;
							ramp_n = '0;
						end else begin
							ramp_n = ramp_q + 1'b1;
						end
					end
					code_n = code;
					for (int i = 0; i < N_PHASE; i++) begin
						case (role[i])
							ROLE_HIGH: begin
								duty_n[i] = cur_n;
								pin_n[i]  = dir_n;
							end
							ROLE_LOW: begin
								duty_n[i] = dcfg.pwm_period;
								pin_n[i]  = ~dir_n;
							end
							default: duty_n[i] = '0;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_PHASE; i++) begin
				duty_q[i] <= '0;
				pin_q[i]  <= 1'b0;
			end
			mode_q <= MODE_SOFT;
			cur_q  <= '0;
			tgt_q  <= '0;
			ramp_q <= '0;
			dir_q  <= 1'b1;
			code_q <= '0;
		end else if (fire) begin
			for (int i = 0; i < N_PHASE; i++) begin
				duty_q[i] <= duty_n[i];
				pin_q[i]  <= pin_n[i];
			end
			mode_q <= mode_n;
			cur_q  <= cur_n;
			tgt_q  <= tgt_n;
			ramp_q <= ramp_n;
			dir_q  <= dir_n;
			code_q <= code_n;
		end
	end

	assign res.duty_a     = duty_q[0];
	assign res.duty_b     = duty_q[1];
	assign res.duty_c     = duty_q[2];
	assign res.pin_a      = pin_q[0];
	assign res.pin_b      = pin_q[1];
	assign res.pin_c      = pin_q[2];
	assign res.run_mode   = mode_q;
	assign res.now_speed  = cur_q;
	assign res.goal_speed = tgt_q;
	assign res.hall_code  = code_q;

	// applied speed never overtakes the target
	a_cur_le_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= tgt_q)
		else $error("applied speed above target");

	// invalid hall code in run mode leaves every phase with zero duty
	a_bad_code_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && tick && (mode_n == MODE_RUN) && ((code == 3'd0) || (code == 3'd7)))
		|=> (duty_q[0] == '0) && (duty_q[1] == '0) && (duty_q[2] == '0))
		else $error("duty left on for invalid hall code");

endmodule

// ===== rtl/bldc_hall_six_step_commutator_core.sv =====
// channel  | handshake          | contents
// ---------+--------------------+-------------------------------------------------
// in       | in_valid/in_stall  | func, hall_a..c, speed_value, mode_value, dir_value
// out      | out_valid/out_stall| duty_a..c, pin_a..c, run_mode, now_speed,
//          |                    | goal_speed, hall_code
// cfg      | cfg_we             | cfg_idx selects register, cfg_data value
//
// One command word per clock while in_stall is low: a word waits in the input register,
// then the motor state registers take its effect and double as the result word.
// out_valid rises when the motor state registers take the word.
// A result waiting on out_stall holds the state; the input register still
// takes one more word, after which in_stall rises.
// Reset (arst_n low) sets the motor state to soft stop, forward, zero speed,
// and every configuration register to its default.
module bldc_hall_six_step_commutator_core (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bhsc_pkg::FUNC_W-1:0]         func,
	input  logic                                hall_a,
	input  logic                                hall_b,
	input  logic                                hall_c,
	input  logic [bhsc_pkg::SPEED_W-1:0]        speed_value,
	input  logic [bhsc_pkg::MODE_W-1:0]         mode_value,
	input  logic                                dir_value,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bhsc_pkg::DUTY_W-1:0]         duty_a,
	output logic [bhsc_pkg::DUTY_W-1:0]         duty_b,
	output logic [bhsc_pkg::DUTY_W-1:0]         duty_c,
	output logic                                pin_a,
	output logic                                pin_b,
	output logic                                pin_c,
	output logic [bhsc_pkg::MODE_W-1:0]         run_mode,
	output logic [bhsc_pkg::SPEED_W-1:0]        now_speed,
	output logic [bhsc_pkg::SPEED_W-1:0]        goal_speed,
	output logic [bhsc_pkg::CODE_W-1:0]         hall_code,

	input  logic                                cfg_we,
	input  logic [bhsc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [bhsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bhsc_pkg::*;

	// configuration registers
	drive_cfg_t dcfg_q;
	order_cfg_t ocfg_q;

	// input register
	cmd_t       cmd_s1;
	logic       vld_s1;

	logic       out_vld_q;
	logic       fire;
	logic       in_take;
	logic [CODE_W-1:0] code;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcfg_q.pwm_period <= PWM_PERIOD_RST;
			dcfg_q.speed_cap  <= SPEED_CAP_RST;
			dcfg_q.jump_limit <= JUMP_LIMIT_RST;
			dcfg_q.ramp_delay <= RAMP_DELAY_RST;
			ocfg_q.a_base     <= HALL_A_BASE_RST;
			ocfg_q.b_base     <= HALL_B_BASE_RST;
			ocfg_q.c_base     <= HALL_C_BASE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_PWM_PERIOD:  dcfg_q.pwm_period <= cfg_data;
				CFG_SPEED_CAP:   dcfg_q.speed_cap  <= cfg_data;
				CFG_JUMP_LIMIT:  dcfg_q.jump_limit <= cfg_data;
				CFG_RAMP_DELAY:  dcfg_q.ramp_delay <= cfg_data;
				CFG_HALL_A_BASE: ocfg_q.a_base     <= cfg_data[POS_W-1:0];
				CFG_HALL_B_BASE: ocfg_q.b_base     <= cfg_data[POS_W-1:0];
				CFG_HALL_C_BASE: ocfg_q.c_base     <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// word in the input register executes once the result slot is free
	assign fire     = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !fire;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1.func        <= func;
			cmd_s1.hall_a      <= hall_a;
			cmd_s1.hall_b      <= hall_b;
			cmd_s1.hall_c      <= hall_c;
			cmd_s1.speed_value <= speed_value;
			cmd_s1.mode_value  <= mode_value;
			cmd_s1.dir_value   <= dir_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	bhsc_hall_order u_order (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.ocfg   (ocfg_q),
		.code   (code)
	);

	bhsc_motor_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.dcfg   (dcfg_q),
		.code   (code),
		.res    (res)
	);

	assign out_valid  = out_vld_q;
	assign duty_a     = res.duty_a;
	assign duty_b     = res.duty_b;
	assign duty_c     = res.duty_c;
	assign pin_a      = res.pin_a;
	assign pin_b      = res.pin_b;
	assign pin_c      = res.pin_c;
	assign run_mode   = res.run_mode;
	assign now_speed  = res.now_speed;
	assign goal_speed = res.goal_speed;
	assign hall_code  = res.hall_code;

	// state only moves when a word executes
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(res))
		else $error("state changed without a command");

	// back-pressure only comes from a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_vld_q && out_stall))
		else $error("input stalled with result slot free");

endmodule

// ===== sim/bldc_hall_six_step_commutator_core_tb.sv =====
`timescale 1ns / 100ps

// Six-step hall commutator bench. Commands are queued by the stimulus block,
// offered by a clocked driver and folded into a shadow motor state as they are
// taken; every taken command predicts one state word. The monitor pops those in
// order and compares field by field. Register settings change between phases
// only once the block has drained.
module bldc_hall_six_step_commutator_core_tb;

	import bhsc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 170;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 6;	// margin past the input and motor state registers

	localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd9;
	localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;
	localparam logic [MODE_W-1:0] MODE_VALUE_BAD = 2'd3;	// set-mode ignores it
	localparam logic [POS_W-1:0] BASE_BAD = 2'd3;	// a base of three reads as zero
	localparam logic DIR_FWD = 1'b1;
	localparam logic DIR_BWD = 1'b0;
	localparam int NO_PHASE = 3;

	logic clk;
	logic arst_n = 1'b0;

	// command side
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic hall_a = 1'b0;
	logic hall_b = 1'b0;
	logic hall_c = 1'b0;
	logic [SPEED_W-1:0] speed_value = '0;
	logic [MODE_W-1:0] mode_value = '0;
	logic dir_value = 1'b0;

	// result side
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DUTY_W-1:0] duty_a, duty_b, duty_c;
	logic pin_a, pin_b, pin_c;
	logic [MODE_W-1:0] run_mode;
	logic [SPEED_W-1:0] now_speed, goal_speed;
	logic [CODE_W-1:0] hall_code;

	// register port
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bldc_hall_six_step_commutator_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .hall_a(hall_a), .hall_b(hall_b), .hall_c(hall_c),
		.speed_value(speed_value), .mode_value(mode_value), .dir_value(dir_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.duty_a(duty_a), .duty_b(duty_b), .duty_c(duty_c),
		.pin_a(pin_a), .pin_b(pin_b), .pin_c(pin_c),
		.run_mode(run_mode), .now_speed(now_speed), .goal_speed(goal_speed),
		.hall_code(hall_code),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// pacing knobs, only changed while the block is drained
	int send_idle_pct = 0;
	int stall_pct = 0;
	int speed_span = 1000;
	logic hold_request = 1'b0;
	logic long_hold = 1'b0;

	int fault_count = 0;
	int cycle_count = 0;

	cmd_t pending_commands[$];
	res_t due_words[$];

	// shadow registers, as written over the register port
	logic [DUTY_W-1:0] sh_period;
	logic [SPEED_W-1:0] sh_max, sh_jump, sh_delay;
	logic [POS_W-1:0] sh_a_base, sh_b_base, sh_c_base;

	// shadow motor state
	logic [DUTY_W-1:0] st_duty [N_PHASE];
	logic st_pin [N_PHASE];
	mode_t st_mode;
	logic [SPEED_W-1:0] st_cur, st_tgt;
	logic [RAMP_W-1:0] st_ramp;
	logic st_dir;
	logic st_row;
	logic [POS_W-1:0] st_rot [2];
	logic [POS_W-1:0] st_pos [N_PHASE];
	logic [CODE_W-1:0] st_code;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// shadow model
	// ---------------------------------------------------------------------

	task automatic shadow_reset;
		sh_period = PWM_PERIOD_RST;
		sh_max = SPEED_CAP_RST;
		sh_jump = JUMP_LIMIT_RST;
		sh_delay = RAMP_DELAY_RST;
		sh_a_base = HALL_A_BASE_RST;
		sh_b_base = HALL_B_BASE_RST;
		sh_c_base = HALL_C_BASE_RST;
		for (int i = 0; i < N_PHASE; i++) begin
			st_duty[i] = '0;
			st_pin[i] = 1'b0;
			st_pos[i] = '0;	// bit order is flat until the first reorder
		end
		st_mode = MODE_SOFT;
		st_cur = '0;
		st_tgt = '0;
		st_ramp = '0;
		st_dir = DIR_FWD;
		st_row = 1'b0;
		st_rot[0] = '0;
		st_rot[1] = '0;
		st_code = '0;
	endtask

	task automatic zero_duties;
		for (int i = 0; i < N_PHASE; i++)
			st_duty[i] = '0;
	endtask

	// one refresh of the phase outputs from the current mode
	task automatic motor_tick(input logic ha, input logic hb, input logic hc);
		logic pass;
		logic [CODE_W-1:0] code;
		int hi, lo;
		case (st_mode)
			MODE_SOFT: zero_duties();
			MODE_HARD: begin
				for (int i = 0; i < N_PHASE; i++) begin
					st_pin[i] = 1'b0;
					st_duty[i] = st_cur;
				end
			end
			MODE_RUN: begin
				// ramp: counter must already exceed the delay before a step
				if (st_cur < st_tgt) begin
					pass = st_ramp > {1'b0, sh_delay};
					st_ramp = st_ramp + 1'b1;
					if (pass) begin
						st_cur = st_cur + 1'b1;
						st_ramp = '0;
					end
				end
				code = ({2'b00, hc} << st_pos[2]) | ({2'b00, hb} << st_pos[1])
					| ({2'b00, ha} << st_pos[0]);
				st_code = code;
				// driven-high and driven-low phase per step; 3 means none
				case (code)
					3'd1: begin hi = 0; lo = 1; end
					3'd2: begin hi = 1; lo = 2; end
					3'd3: begin hi = 0; lo = 2; end
					3'd4: begin hi = 2; lo = 0; end
					3'd5: begin hi = 2; lo = 1; end
					3'd6: begin hi = 1; lo = 0; end
					default: begin hi = NO_PHASE; lo = NO_PHASE; end
				endcase
				for (int i = 0; i < N_PHASE; i++) begin
					if (i == hi) begin
						st_pin[i] = st_dir;
						st_duty[i] = st_cur;
					end else if (i == lo) begin
						st_pin[i] = ~st_dir;
						st_duty[i] = sh_period;
					end else begin
						st_duty[i] = '0;	// off phase keeps its pin
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic speed_command(input logic [SPEED_W-1:0] req, input logic ha,
			input logic hb, input logic hc);
		logic [SPEED_W-1:0] v;
		v = req;
		// repeat of the current target is a no-op, checked before the clamp
		if (v != st_tgt) begin
			if (v > sh_max)
				v = sh_max;
			st_tgt = v;
			if (!(v > st_cur && (v - st_cur) > sh_jump))
				st_cur = v;
			if (v == '0) begin
				if (st_mode != MODE_SOFT) begin
					st_mode = MODE_SOFT;
					zero_duties();
				end
			end else begin
				st_mode = MODE_RUN;
				motor_tick(ha, hb, hc);
			end
		end
	endtask

	task automatic next_order;
		int a, b, c, r, t;
		st_row = ~st_row;
		r = st_rot[st_row];
		r = (r >= 2) ? 0 : r + 1;
		st_rot[st_row] = POS_W'(r);
		a = (sh_a_base == BASE_BAD) ? 0 : sh_a_base;
		b = (sh_b_base == BASE_BAD) ? 0 : sh_b_base;
		c = (sh_c_base == BASE_BAD) ? 0 : sh_c_base;
		if (st_row) begin	// second row swaps B and C
			t = b;
			b = c;
			c = t;
		end
		st_pos[0] = POS_W'((a + r) % 3);
		st_pos[1] = POS_W'((b + r) % 3);
		st_pos[2] = POS_W'((c + r) % 3);
	endtask

	// fold one taken command into the shadow state, queue the word it yields
	task automatic apply_command(input cmd_t c);
		res_t w;
		case (c.func)
			FN_TICK: motor_tick(c.hall_a, c.hall_b, c.hall_c);
			FN_SET_SPEED: speed_command(c.speed_value, c.hall_a, c.hall_b, c.hall_c);
			FN_SET_MODE: begin
				if (c.mode_value != MODE_VALUE_BAD && c.mode_value != st_mode) begin
					st_mode = mode_t'(c.mode_value);
					motor_tick(c.hall_a, c.hall_b, c.hall_c);
				end
			end
			FN_FORWARD: begin
				st_dir = DIR_FWD;
				speed_command(c.speed_value, c.hall_a, c.hall_b, c.hall_c);
			end
			FN_BACKWARD: begin
				st_dir = DIR_BWD;
				speed_command(c.speed_value, c.hall_a, c.hall_b, c.hall_c);
			end
			FN_SET_DIR: st_dir = c.dir_value;
			FN_TOGGLE_DIR: st_dir = ~st_dir;
			FN_NEXT_ORDER: next_order();
			FN_START: begin
				st_mode = MODE_RUN;
				motor_tick(c.hall_a, c.hall_b, c.hall_c);
			end
			default: ;	// unused codes leave everything as is
		endcase
		w.duty_a = st_duty[0];
		w.duty_b = st_duty[1];
		w.duty_c = st_duty[2];
		w.pin_a = st_pin[0];
		w.pin_b = st_pin[1];
		w.pin_c = st_pin[2];
		w.run_mode = st_mode;
		w.now_speed = st_cur;
		w.goal_speed = st_tgt;
		w.hall_code = st_code;
		due_words.push_back(w);
	endtask

	// ---------------------------------------------------------------------
	// driver: offers queued commands, shadows each one as it is taken
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : drive
		cmd_t taken, nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				taken = {func, hall_a, hall_b, hall_c, speed_value, mode_value, dir_value};
				apply_command(taken);
			end
			// slot frees once the word on the pins is taken or none was offered
			if (!in_valid || !in_stall) begin
				if (pending_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_commands.pop_front();
					func <= nxt.func;
					hall_a <= nxt.hall_a;
					hall_b <= nxt.hall_b;
					hall_c <= nxt.hall_c;
					speed_value <= nxt.speed_value;
					mode_value <= nxt.mode_value;
					dir_value <= nxt.dir_value;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// monitor
	// ---------------------------------------------------------------------

	function automatic string describe(input res_t w);
		return $sformatf("duty %0d/%0d/%0d pin %b%b%b mode %0d speed %0d goal %0d code %0d",
			w.duty_a, w.duty_b, w.duty_c, w.pin_a, w.pin_b, w.pin_c,
			w.run_mode, w.now_speed, w.goal_speed, w.hall_code);
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : watch
		res_t got, want;
		string bad;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {duty_a, duty_b, duty_c, pin_a, pin_b, pin_c, run_mode,
					now_speed, goal_speed, hall_code};
				if (due_words.size() == 0) begin
					note_fault({"result word with none due: ", describe(got)});
				end else begin
					want = due_words.pop_front();
					bad = "";
					if (got.duty_a !== want.duty_a) bad = {bad, " duty_a"};
					if (got.duty_b !== want.duty_b) bad = {bad, " duty_b"};
					if (got.duty_c !== want.duty_c) bad = {bad, " duty_c"};
					if (got.pin_a !== want.pin_a) bad = {bad, " pin_a"};
					if (got.pin_b !== want.pin_b) bad = {bad, " pin_b"};
					if (got.pin_c !== want.pin_c) bad = {bad, " pin_c"};
					if (got.run_mode !== want.run_mode) bad = {bad, " run_mode"};
					if (got.now_speed !== want.now_speed) bad = {bad, " now_speed"};
					if (got.goal_speed !== want.goal_speed) bad = {bad, " goal_speed"};
					if (got.hall_code !== want.hall_code) bad = {bad, " hall_code"};
					if (bad != "")
						note_fault({"mismatch in", bad, "\n  expected ", describe(want),
							"\n  actual   ", describe(got)});
				end
			end
			out_stall <= long_hold || ($urandom_range(0, 99) < stall_pct);
		end
	end

	// long receiver hold-off, counted here so the block backs up into in_stall
	initial begin
		wait (hold_request);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// ---------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------

	function automatic cmd_t cmd_word(input logic [FUNC_W-1:0] f, input logic [2:0] halls,
			input logic [SPEED_W-1:0] spd, input logic [MODE_W-1:0] mv, input logic dv);
		cmd_t c;
		c.func = f;
		{c.hall_a, c.hall_b, c.hall_c} = halls;
		c.speed_value = spd;
		c.mode_value = mv;
		c.dir_value = dv;
		return c;
	endfunction

	// ticks most often, with speed requests sized to the phase
	function automatic cmd_t random_cmd;
		cmd_t c;
		int pick, sel;
		c.hall_a = 1'($urandom_range(0, 1));
		c.hall_b = 1'($urandom_range(0, 1));
		c.hall_c = 1'($urandom_range(0, 1));
		c.speed_value = SPEED_W'($urandom);
		c.mode_value = MODE_W'($urandom_range(0, 3));
		c.dir_value = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 45) c.func = FN_TICK;
		else if (pick < 52) c.func = FN_SET_SPEED;
		else if (pick < 57) c.func = FN_FORWARD;
		else if (pick < 62) c.func = FN_BACKWARD;
		else if (pick < 70) c.func = FN_SET_MODE;
		else if (pick < 75) c.func = FN_SET_DIR;
		else if (pick < 79) c.func = FN_TOGGLE_DIR;
		else if (pick < 87) c.func = FN_NEXT_ORDER;
		else if (pick < 96) c.func = FN_START;
		else c.func = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
		if (c.func == FN_SET_SPEED || c.func == FN_FORWARD || c.func == FN_BACKWARD) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				c.speed_value = '0;
			else if (sel >= 3)
				c.speed_value = SPEED_W'($urandom_range(1, speed_span));
		end
		return c;
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PWM_PERIOD: sh_period = value;
			CFG_SPEED_CAP: sh_max = value;
			CFG_JUMP_LIMIT: sh_jump = value;
			CFG_RAMP_DELAY: sh_delay = value;
			CFG_HALL_A_BASE: sh_a_base = value[POS_W-1:0];
			CFG_HALL_B_BASE: sh_b_base = value[POS_W-1:0];
			CFG_HALL_C_BASE: sh_c_base = value[POS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [15:0] period, input logic [15:0] maxs,
			input logic [15:0] jump, input logic [15:0] delay,
			input logic [1:0] a, input logic [1:0] b, input logic [1:0] c);
		write_reg(CFG_PWM_PERIOD, period);
		write_reg(CFG_SPEED_CAP, maxs);
		write_reg(CFG_JUMP_LIMIT, jump);
		write_reg(CFG_RAMP_DELAY, delay);
		write_reg(CFG_HALL_A_BASE, {14'd0, a});
		write_reg(CFG_HALL_B_BASE, {14'd0, b});
		write_reg(CFG_HALL_C_BASE, {14'd0, c});
	endtask

	// sampled on the falling edge so driver and monitor have settled
	task automatic drain;
		@(negedge clk);
		while (pending_commands.size() != 0 || in_valid || due_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int hold_pct, input logic hold,
			input int span);
		@(negedge clk);
		send_idle_pct = send_pct;
		stall_pct = hold_pct;
		speed_span = span;
		repeat (PHASE_ITEMS) pending_commands.push_back(random_cmd());
		if (hold)
			hold_request = 1'b1;
		drain();
	endtask

	initial begin
		shadow_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed words on the reset settings; bit order flat to begin with
		pending_commands.push_back(cmd_word(FN_TICK, 3'b111, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_SET_SPEED, 3'b000, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_START, 3'b100, 16'hFFFF, MODE_VALUE_BAD, 1'b1));
		// clamped to max and too big a jump: target set, speed left to ramp
		pending_commands.push_back(cmd_word(FN_SET_SPEED, 3'b101, 16'hFFFF, MODE_RUN, 1'b1));
		pending_commands.push_back(cmd_word(FN_NEXT_ORDER, 3'b000, 16'd0, MODE_SOFT, 1'b0));
		// reordered: A on bit 1, B on bit 0, C on bit 2 - walk every code
		pending_commands.push_back(cmd_word(FN_TICK, 3'b010, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_TICK, 3'b100, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_TICK, 3'b110, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_TICK, 3'b001, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_TICK, 3'b011, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_TICK, 3'b101, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_TICK, 3'b000, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_TICK, 3'b111, 16'hFFFF, MODE_VALUE_BAD, 1'b1));
		pending_commands.push_back(cmd_word(FN_SET_MODE, 3'b110, 16'd0, MODE_VALUE_BAD, 1'b0));
		pending_commands.push_back(cmd_word(FN_SET_MODE, 3'b110, 16'd0, MODE_HARD, 1'b0));
		pending_commands.push_back(cmd_word(FN_SET_MODE, 3'b110, 16'd0, MODE_HARD, 1'b0));
		pending_commands.push_back(cmd_word(FN_SET_DIR, 3'b000, 16'd0, MODE_SOFT, DIR_BWD));
		pending_commands.push_back(cmd_word(FN_TOGGLE_DIR, 3'b000, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_FORWARD, 3'b010, 16'd500, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_BACKWARD, 3'b010, 16'd0, MODE_SOFT, 1'b0));
		pending_commands.push_back(cmd_word(FN_SET_MODE, 3'b011, 16'd0, MODE_RUN, 1'b0));
		pending_commands.push_back(cmd_word(FN_UNUSED_LO, 3'b111, 16'hFFFF, MODE_RUN, 1'b1));
		pending_commands.push_back(cmd_word(FN_UNUSED_HI, 3'b111, 16'hFFFF, MODE_RUN, 1'b1));
		pending_commands.push_back(cmd_word(FN_SET_MODE, 3'b000, 16'd0, MODE_SOFT, 1'b0));
		drain();

		// full-scale everything, instant speed changes, back to back
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 2'd0, 2'd1, 2'd2);
		run_phase(0, 0, 1'b0, 65535);

		// low period, cap and jump limit, longest ramp delay, sender gaps
		configure(16'd1, 16'd0, 16'd0, 16'hFFFF, 2'd2, 2'd1, 2'd0);
		run_phase(63, 0, 1'b0, 1000);

		// small jump limit so most requests ramp; bases of three, receiver stalls
		configure(16'd4000, 16'd3000, 16'd20, 16'd0, BASE_BAD, BASE_BAD, BASE_BAD);
		run_phase(0, 63, 1'b0, 200);

		// near-default drive, both sides idling
		configure(16'd12000, 16'd8800, 16'd1320, 16'd1, 2'd1, 2'd2, 2'd0);
		run_phase(30, 30, 1'b0, 2000);

		// back-pressure: receiver holds off while the sender keeps offering
		configure(16'($urandom_range(1, 65535)), 16'd500, 16'd10, 16'd2, 2'd2, 2'd0, 2'd1);
		run_phase(0, 0, 1'b1, 100);

		// random settings
		configure(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom_range(0, 50)),
			16'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
			2'($urandom_range(0, 3)));
		run_phase(30, 30, 1'b0, 300);

		// watch for stray words after the last one due
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
